// ===== hw/rtl/rmd_pkg.sv =====
// rmd_pkg: shared types and constants of the rgba 2x2 mip downsampler
// holds pixel, result and lane-sum payload types, register codes and field widths
// no dependencies

package rmd_pkg;

   // field and counter widths fixed by the register and pixel formats
   localparam int CHANNEL_WIDTH   = 8;
   localparam int LANE_WIDTH      = 9;
   localparam int COLUMN_WIDTH    = 12;
   localparam int ROW_WIDTH       = 17;
   localparam int OUT_WIDTH_BITS  = 12;
   localparam int OUT_HEIGHT_BITS = 16;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUT_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUT_HEIGHT = 1'd1;

   // one source pixel
   typedef struct packed {
      logic [CHANNEL_WIDTH-1:0] red_in;
      logic [CHANNEL_WIDTH-1:0] green_in;
      logic [CHANNEL_WIDTH-1:0] blue_in;
      logic [CHANNEL_WIDTH-1:0] alpha_in;
   } pixel_type;

   // one downsampled pixel
   typedef struct packed {
      logic [CHANNEL_WIDTH-1:0] red_out;
      logic [CHANNEL_WIDTH-1:0] green_out;
      logic [CHANNEL_WIDTH-1:0] blue_out;
      logic [CHANNEL_WIDTH-1:0] alpha_out;
      logic                     last_pixel;
   } result_type;

   // horizontal pair sums, one lane per channel
   typedef struct packed {
      logic [LANE_WIDTH-1:0] red;
      logic [LANE_WIDTH-1:0] green;
      logic [LANE_WIDTH-1:0] blue;
      logic [LANE_WIDTH-1:0] alpha;
   } lane_sum_type;

   localparam int LANE_SUM_BITS = $bits(lane_sum_type);

   // scan position flags handed from the counters to the datapath
   typedef struct packed {
      logic right_pixel;
      logic odd_row;
      logic image_end;
   } scan_type;

endpackage

// ===== hw/rtl/rmd_stream_if.sv =====
// rmd_stream_if: valid/ready stream channel with a typed payload
// source drives valid and payload, sink drives ready
// no dependencies

interface rmd_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/rmd_line_store.sv =====
// rmd_line_store: single-port-write, single-port-read line memory
// read data registered and held while no read is issued
// no dependencies

module rmd_line_store #(
   parameter int  DEPTH = 2048,
   parameter int  WIDTH = 36,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             write_enable,
   input  logic [AW-1:0]    write_index,
   input  logic [WIDTH-1:0] write_data,
   input  logic             read_enable,
   input  logic [AW-1:0]    read_index,
   output logic [WIDTH-1:0] read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_index] <= write_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (read_enable) begin
         read_data_ff <= mem[read_index];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ===== hw/rtl/rmd_scan_ctrl.sv =====
// rmd_scan_ctrl: configuration registers and raster position counters
// tracks pair phase, output column and source row; gives store index, pair phase, odd row and image end
// depends on rmd_pkg

module rmd_scan_ctrl #(
   parameter int  MAX_OUT_WIDTH = 2048,
   localparam int AW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [rmd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [rmd_pkg::CSR_DATA_WIDTH-1:0]    csr_data,
   input  logic                                  pixel_transfer,
   output rmd_pkg::scan_type                     scan,
   output logic [AW-1:0]                         store_index
);

   // compare width wide enough for the column counter and the store depth value
   localparam int IW = ((AW > rmd_pkg::COLUMN_WIDTH) ? AW : rmd_pkg::COLUMN_WIDTH) + 1;

   logic [rmd_pkg::OUT_WIDTH_BITS-1:0]  width_ff,  width_in;
   logic [rmd_pkg::OUT_HEIGHT_BITS-1:0] height_ff, height_in;
   logic [rmd_pkg::COLUMN_WIDTH-1:0]    column_ff, column_in;
   logic [rmd_pkg::ROW_WIDTH-1:0]       row_ff,    row_in;
   logic                                phase_ff,  phase_in;

   logic [IW-1:0]                       column_ext;
   logic [IW-1:0]                       width_ext;
   logic [IW-1:0]                       depth_ext;
   logic [IW-1:0]                       eff_width;
   logic [rmd_pkg::OUT_HEIGHT_BITS-1:0] eff_height;
   logic [rmd_pkg::ROW_WIDTH-1:0]       last_row;
   logic                                column_end;
   logic                                row_end;

   // effective geometry: zero reads as one, width clamped to the store depth
   always_comb begin
      column_ext = IW'(column_ff);
      width_ext  = IW'(width_ff);
      depth_ext  = IW'(MAX_OUT_WIDTH);
      if (width_ext == '0) begin
         eff_width = IW'(1);
      end else if (width_ext > depth_ext) begin
         eff_width = depth_ext;
      end else begin
         eff_width = width_ext;
      end
      eff_height = (height_ff == '0) ? rmd_pkg::OUT_HEIGHT_BITS'(1) : height_ff;
      last_row   = {eff_height - rmd_pkg::OUT_HEIGHT_BITS'(1), 1'b1};
      column_end = column_ext >= (eff_width - IW'(1));
      row_end    = row_ff >= last_row;
   end

   // next state of registers and counters
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      column_in = column_ff;
      row_in    = row_ff;
      phase_in  = phase_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            rmd_pkg::CSR_OUT_WIDTH: begin
               width_in = csr_data[rmd_pkg::OUT_WIDTH_BITS-1:0];
            end
            rmd_pkg::CSR_OUT_HEIGHT: begin
               height_in = csr_data[rmd_pkg::OUT_HEIGHT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
      if (pixel_transfer) begin
         if (!phase_ff) begin
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            if (column_end) begin
               column_in = '0;
               row_in    = row_end ? '0 : row_ff + rmd_pkg::ROW_WIDTH'(1);
            end else begin
               column_in = column_ff + rmd_pkg::COLUMN_WIDTH'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rmd_pkg::OUT_WIDTH_BITS'(1);
         height_ff <= rmd_pkg::OUT_HEIGHT_BITS'(1);
         column_ff <= '0;
         row_ff    <= '0;
         phase_ff  <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         column_ff <= column_in;
         row_ff    <= row_in;
         phase_ff  <= phase_in;
      end
   end

   // status towards the datapath
   assign scan.right_pixel = phase_ff;
   assign scan.odd_row     = row_ff[0];
   assign scan.image_end   = column_end && row_end;
   assign store_index      = (column_ext < depth_ext) ? column_ext[AW-1:0] : '0;

endmodule

// ===== hw/rtl/rgba_mip_downsample_2x2.sv =====
// rgba_mip_downsample_2x2: rgba8 2x2 box-filter mip level downsampler
// depends on rmd_pkg, rmd_stream_if, rmd_line_store, rmd_scan_ctrl
// output: a result is valid in the cycle after the transfer of the quad's last source pixel
// throughput: one source pixel per cycle unless an odd-row right pixel waits on a full
//   output register; at most one store read (odd-row left) or write (even-row right)
// reset: counters, phase and output valid cleared, sizes set to one; line store not cleared

module rgba_mip_downsample_2x2 #(
   parameter int MAX_OUT_WIDTH = 2048
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [rmd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [rmd_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   rmd_stream_if.sink                          req,
   rmd_stream_if.source                        rsp
);

   localparam int AW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

   rmd_pkg::scan_type     scan;
   logic [AW-1:0]         store_index;
   logic                  pixel_transfer;
   logic                  store_read;
   logic                  store_write;
   logic                  result_load;
   logic [rmd_pkg::LANE_SUM_BITS-1:0] store_read_data;

   rmd_pkg::pixel_type    pixel;
   rmd_pkg::pixel_type    left_ff;
   rmd_pkg::lane_sum_type pair_sum;
   rmd_pkg::lane_sum_type upper_sum;
   rmd_pkg::result_type   result;
   rmd_pkg::result_type   rsp_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;

   // sum of one channel over four samples, divided by four
   function automatic logic [rmd_pkg::CHANNEL_WIDTH-1:0] quad_avg(
      input logic [rmd_pkg::LANE_WIDTH-1:0] upper,
      input logic [rmd_pkg::LANE_WIDTH-1:0] lower
   );
      logic [rmd_pkg::LANE_WIDTH:0] total;
      total = {1'b0, upper} + {1'b0, lower};
      return total[rmd_pkg::LANE_WIDTH:2];
   endfunction

   assign pixel = req.payload;

   // a pixel that causes no result never waits on the output register
   assign req.ready      = !(scan.right_pixel && scan.odd_row) || !rsp_valid_ff || rsp.ready;
   assign pixel_transfer = req.valid && req.ready;
   assign store_read     = pixel_transfer && !scan.right_pixel && scan.odd_row;
   assign store_write    = pixel_transfer && scan.right_pixel && !scan.odd_row;
   assign result_load    = pixel_transfer && scan.right_pixel && scan.odd_row;

   rmd_scan_ctrl #(
      .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
   ) u_scan_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .pixel_transfer   (pixel_transfer),
      .scan             (scan),
      .store_index      (store_index)
   );

   // even-row pair sums, read back one pixel ahead of the odd-row right pixel
   rmd_line_store #(
      .DEPTH (MAX_OUT_WIDTH),
      .WIDTH (rmd_pkg::LANE_SUM_BITS)
   ) u_line_store (
      .clock        (clock),
      .write_enable (store_write),
      .write_index  (store_index),
      .write_data   (pair_sum),
      .read_enable  (store_read),
      .read_index   (store_index),
      .read_data    (store_read_data)
   );

   // left pixel of the current pair
   always_ff @(posedge clock) begin
      if (pixel_transfer && !scan.right_pixel) begin
         left_ff <= pixel;
      end
   end

   // horizontal pair sum and quad average
   always_comb begin
      pair_sum.red   = {1'b0, left_ff.red_in}   + {1'b0, pixel.red_in};
      pair_sum.green = {1'b0, left_ff.green_in} + {1'b0, pixel.green_in};
      pair_sum.blue  = {1'b0, left_ff.blue_in}  + {1'b0, pixel.blue_in};
      pair_sum.alpha = {1'b0, left_ff.alpha_in} + {1'b0, pixel.alpha_in};
      upper_sum      = rmd_pkg::lane_sum_type'(store_read_data);
      result.red_out    = quad_avg(upper_sum.red,   pair_sum.red);
      result.green_out  = quad_avg(upper_sum.green, pair_sum.green);
      result.blue_out   = quad_avg(upper_sum.blue,  pair_sum.blue);
      result.alpha_out  = quad_avg(upper_sum.alpha, pair_sum.alpha);
      result.last_pixel = scan.image_end;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

endmodule

// ===== sim/rmd_downsample_checker.sv =====
// rmd_downsample_checker: scoreboard for the rgba 2x2 mip downsampler
// tracks register writes and pixel transfers, predicts each averaged pixel and compares it
// depends on rmd_pkg

module rmd_downsample_checker #(
   parameter int LINE_DEPTH = 2048
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [rmd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [rmd_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  rmd_pkg::pixel_type                  req_payload,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  rmd_pkg::result_type                 rsp_payload,
   output logic                                odd_row,
   output int                                  pending_results,
   output int                                  failures
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow of the size registers and the scan position
   logic [rmd_pkg::OUT_WIDTH_BITS-1:0]  width_reg;
   logic [rmd_pkg::OUT_HEIGHT_BITS-1:0] height_reg;
   logic [rmd_pkg::COLUMN_WIDTH-1:0]    quad_column;
   logic [rmd_pkg::ROW_WIDTH-1:0]       quad_row;
   logic                                right_half;
   rmd_pkg::pixel_type                  left_pixel;

   // even-row pair sums, one entry per output column
   rmd_pkg::lane_sum_type line_sums [LINE_DEPTH];

   rmd_pkg::result_type expected_pixels [$];
   int                  error_count = 0;

   // floor of the four-sample mean from two pair sums
   function automatic logic [rmd_pkg::CHANNEL_WIDTH-1:0] quad_mean(
      input logic [rmd_pkg::LANE_WIDTH-1:0] upper,
      input logic [rmd_pkg::LANE_WIDTH-1:0] lower
   );
      logic [rmd_pkg::LANE_WIDTH:0] total;
      total = {1'b0, upper} + {1'b0, lower};
      return total[rmd_pkg::LANE_WIDTH:2];
   endfunction

   // one source pixel: pair it up, store or average, then step the scan
   task automatic accumulate_quad(input rmd_pkg::pixel_type px);
      int unsigned           span;
      int unsigned           last_row;
      int unsigned           slot;
      logic                  col_end;
      logic                  row_end;
      rmd_pkg::lane_sum_type pair;
      rmd_pkg::lane_sum_type above;
      rmd_pkg::result_type   avg;
      if (!right_half) begin
         left_pixel = px;
         right_half = 1'b1;
         return;
      end
      span = (width_reg == 0) ? 1 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg);
      last_row = 2 * ((height_reg == 0) ? 1 : height_reg) - 1;
      col_end = quad_column >= span - 1;
      row_end = quad_row >= last_row;
      slot = (quad_column < LINE_DEPTH) ? quad_column : 0;

      pair.red   = rmd_pkg::LANE_WIDTH'(left_pixel.red_in)   + rmd_pkg::LANE_WIDTH'(px.red_in);
      pair.green = rmd_pkg::LANE_WIDTH'(left_pixel.green_in) + rmd_pkg::LANE_WIDTH'(px.green_in);
      pair.blue  = rmd_pkg::LANE_WIDTH'(left_pixel.blue_in)  + rmd_pkg::LANE_WIDTH'(px.blue_in);
      pair.alpha = rmd_pkg::LANE_WIDTH'(left_pixel.alpha_in) + rmd_pkg::LANE_WIDTH'(px.alpha_in);

      if (!quad_row[0]) begin
         line_sums[slot] = pair;
      end else begin
         above = line_sums[slot];
         avg.red_out    = quad_mean(above.red, pair.red);
         avg.green_out  = quad_mean(above.green, pair.green);
         avg.blue_out   = quad_mean(above.blue, pair.blue);
         avg.alpha_out  = quad_mean(above.alpha, pair.alpha);
         avg.last_pixel = col_end && row_end;
         expected_pixels.push_back(avg);
      end

      // counters wrap once they reach or pass the configured edge
      right_half = 1'b0;
      if (col_end) begin
         quad_column = '0;
         quad_row = row_end ? '0 : quad_row + 1'b1;
      end else begin
         quad_column = quad_column + 1'b1;
      end
   endtask

   task automatic compare_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   // one result transfer against the oldest prediction
   task automatic check_result(input rmd_pkg::result_type got);
      rmd_pkg::result_type want;
      if (expected_pixels.size() == 0) begin
         $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
         error_count++;
         return;
      end
      want = expected_pixels.pop_front();
      compare_field("red_out", want.red_out, got.red_out);
      compare_field("green_out", want.green_out, got.green_out);
      compare_field("blue_out", want.blue_out, got.blue_out);
      compare_field("alpha_out", want.alpha_out, got.alpha_out);
      compare_field("last_pixel", 8'(want.last_pixel), 8'(got.last_pixel));
   endtask

   // everything is sampled at the rising edge, before the block updates
   always @(posedge clock) begin
      if (reset) begin
         width_reg   = rmd_pkg::OUT_WIDTH_BITS'(1);
         height_reg  = rmd_pkg::OUT_HEIGHT_BITS'(1);
         quad_column = '0;
         quad_row    = '0;
         right_half  = 1'b0;
         left_pixel  = '0;
         expected_pixels.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == rmd_pkg::CSR_OUT_WIDTH) begin
               width_reg = csr_data[rmd_pkg::OUT_WIDTH_BITS-1:0];
            end else if (csr_index == rmd_pkg::CSR_OUT_HEIGHT) begin
               height_reg = csr_data[rmd_pkg::OUT_HEIGHT_BITS-1:0];
            end
         end
         if (rsp_valid && rsp_ready) begin
            check_result(rsp_payload);
         end
         if (req_valid && req_ready) begin
            accumulate_quad(req_payload);
         end
      end
      odd_row         <= quad_row[0];
      pending_results <= expected_pixels.size();
      failures        <= error_count;
   end

endmodule

// ===== sim/tb.sv =====
// tb: top of the rgba 2x2 mip downsampler testbench
// drives pixels, size registers and result back-pressure; the scoreboard judges each result
// depends on rmd_pkg, rmd_stream_if, rgba_mip_downsample_2x2, rmd_downsample_checker

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_DEPTH    = 2048;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_PIXELS = 400;

   typedef enum {READY_ALWAYS, READY_RANDOM, READY_SPARSE} ready_pattern_type;

   logic                                clock;
   logic                                reset;
   logic                                csr_write_enable;
   logic [rmd_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [rmd_pkg::CSR_DATA_WIDTH-1:0]  csr_data;
   logic                                in_odd_row;

   int                pending_results;
   int                failures;
   int                cycle_count = 0;
   int                burst_left  = 0;
   int                stall_left  = 0;
   ready_pattern_type ready_pattern = READY_ALWAYS;

   rmd_stream_if #(.payload_type(rmd_pkg::pixel_type))  req_ch ();
   rmd_stream_if #(.payload_type(rmd_pkg::result_type)) rsp_ch ();

   rgba_mip_downsample_2x2 #(
      .MAX_OUT_WIDTH(LINE_DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req              (req_ch),
      .rsp              (rsp_ch)
   );

   rmd_downsample_checker #(
      .LINE_DEPTH(LINE_DEPTH)
   ) quad_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .req_payload      (req_ch.payload),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_payload      (rsp_ch.payload),
      .odd_row          (in_odd_row),
      .pending_results  (pending_results),
      .failures         (failures)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result back-pressure: patterns held for random stretches
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_left = $urandom_range(16, 200);
         ready_pattern = ready_pattern_type'($urandom_range(0, 2));
      end
      stall_left--;
      case (ready_pattern)
         READY_ALWAYS: rsp_ch.ready <= 1'b1;
         READY_RANDOM: rsp_ch.ready <= 1'($urandom_range(0, 1));
         default:      rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   function automatic rmd_pkg::pixel_type rgba(input logic [7:0] r, g, b, a);
      rmd_pkg::pixel_type px;
      px.red_in   = r;
      px.green_in = g;
      px.blue_in  = b;
      px.alpha_in = a;
      return px;
   endfunction

   // channel values lean towards the extremes
   function automatic logic [7:0] random_channel();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic rmd_pkg::pixel_type random_pixel();
      return rgba(random_channel(), random_channel(), random_channel(), random_channel());
   endfunction

   // pixel transfers in bursts with random gaps, valid dropped at the end
   task automatic send_pixels(input rmd_pkg::pixel_type pixels[$]);
      int gap;
      foreach (pixels[i]) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         req_ch.valid   <= 1'b1;
         req_ch.payload <= pixels[i];
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
         burst_left--;
      end
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // hold off until every predicted result has arrived, plus the output stage
   task automatic drain_results();
      do @(posedge clock); while (pending_results != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(input logic [rmd_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 input logic [rmd_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      rmd_pkg::pixel_type pixels[$];
      logic [15:0]        size;
      int                 random_sent;

      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      req_ch.valid     = 1'b0;
      req_ch.payload   = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset size of one by one, full-scale quad
      pixels = '{rgba(255, 255, 255, 255), rgba(255, 255, 255, 255),
                 rgba(255, 255, 255, 255), rgba(255, 255, 255, 255)};
      send_pixels(pixels);
      drain_results();

      // zero sizes behave as one; quad sums that must round down
      write_register(rmd_pkg::CSR_OUT_WIDTH, 16'hF000);
      write_register(rmd_pkg::CSR_OUT_HEIGHT, 16'h0000);
      pixels = '{rgba(0, 1, 255, 0), rgba(0, 1, 255, 255),
                 rgba(0, 1, 255, 0), rgba(3, 0, 254, 255)};
      send_pixels(pixels);
      drain_results();

      // widest line, then narrowed part-way along the first row so the column
      // counter already sits beyond the new edge
      write_register(rmd_pkg::CSR_OUT_WIDTH, 16'h0800);
      pixels = '{rgba(0, 0, 0, 0), rgba(255, 255, 255, 255), rgba(255, 0, 255, 0),
                 rgba(0, 255, 0, 255), rgba(128, 127, 1, 254), rgba(127, 128, 254, 1)};
      send_pixels(pixels);
      drain_results();
      write_register(rmd_pkg::CSR_OUT_WIDTH, 16'h0003);
      pixels = '{rgba(9, 8, 7, 6), rgba(5, 4, 3, 2),
                 rgba(255, 255, 255, 255), rgba(255, 255, 255, 255),
                 rgba(0, 0, 0, 0), rgba(255, 255, 255, 255),
                 rgba(1, 2, 3, 4), rgba(250, 251, 252, 253)};
      send_pixels(pixels);
      drain_results();
      write_register(rmd_pkg::CSR_OUT_WIDTH, 16'h0002);
      write_register(rmd_pkg::CSR_OUT_HEIGHT, 16'h0002);

      // random segments, sizes changed at idle points anywhere in the image
      random_sent = 0;
      while (random_sent < RANDOM_PIXELS) begin
         pixels.delete();
         repeat ($urandom_range(2, 40)) pixels.push_back(random_pixel());
         random_sent += pixels.size();
         send_pixels(pixels);
         if ($urandom_range(0, 2) == 0) begin
            drain_results();
            // width only moves while an even row is filling the line store
            if ($urandom_range(0, 1) == 1 && !in_odd_row) begin
               case ($urandom_range(0, 19))
                  0:       size = 16'd0;
                  1:       size = 16'h0FFF;
                  2:       size = 16'(LINE_DEPTH);
                  3:       size = 16'($urandom_range(LINE_DEPTH + 1, 4095));
                  default: size = 16'($urandom_range(1, 6));
               endcase
               write_register(rmd_pkg::CSR_OUT_WIDTH, {4'($urandom), size[11:0]});
            end
            if ($urandom_range(0, 1) == 1) begin
               case ($urandom_range(0, 19))
                  0:       size = 16'd0;
                  1:       size = 16'hFFFF;
                  2:       size = 16'($urandom_range(5, 65534));
                  default: size = 16'($urandom_range(1, 3));
               endcase
               write_register(rmd_pkg::CSR_OUT_HEIGHT, size);
            end
         end
      end

      // final drain and verdict
      drain_results();
      repeat (8) @(posedge clock);
      if (failures == 0 && pending_results == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/rmd_pkg.sv
hw/rtl/rmd_stream_if.sv
hw/rtl/rmd_line_store.sv
hw/rtl/rmd_scan_ctrl.sv
hw/rtl/rgba_mip_downsample_2x2.sv
sim/rmd_downsample_checker.sv
sim/tb.sv
